### rtl/sfxlr_pkg.sv
// sfxlr_pkg: shared widths, codes and the command format of the lump resampler
// used by the front parser, the command queue and the sample engine
`default_nettype none

package sfxlr_pkg;

	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 31;
	localparam int PCM_W    = 16;
	localparam int STATUS_W = 2;
	localparam int RATE_W   = 17;
	localparam int IDX_W    = 32;
	localparam int POS_W    = 48;
	localparam int FRAC_W   = 16;
	// frame count field wide enough for the largest supported frame limit
	localparam int TOTAL_W  = 25;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_SAMPLE     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_HEADER = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EARLY_END  = 2'd2;

	// command kinds from the front to the back
	localparam logic [1:0] CMD_ERR    = 2'd0;
	localparam logic [1:0] CMD_START  = 2'd1;
	localparam logic [1:0] CMD_SAMPLE = 2'd2;

	// header constants
	localparam logic [BYTE_W-1:0] MAGIC0      = 8'h03;
	localparam logic [BYTE_W-1:0] MAGIC1      = 8'h00;
	localparam logic [IDX_W-1:0]  HEADER_LEN  = 32'd8;
	localparam logic [IDX_W-1:0]  MIN_COUNT   = 32'd48;
	localparam logic [IDX_W-1:0]  PAD_BYTES   = 32'd32;
	localparam logic [IDX_W-1:0]  LEAD_BYTES  = 32'd24;
	localparam logic [15:0]       SRC_RATE_MIN = 16'd4000;
	localparam logic [16:0]       SRC_RATE_MAX = 17'd96000;
	// a step at or below this lets one sample byte need more than six outputs
	localparam logic [POS_W-1:0]  STEP_LIMIT  = 48'(32'hFFFF / 6);
	localparam logic [3:0]        BURST_MAX   = 4'd11;
	localparam logic [BYTE_W:0]   CENTER      = 9'd128;

	typedef struct packed {
		logic [1:0]          kind;
		logic [STATUS_W-1:0] status;
		logic [BYTE_W-1:0]   data;
		logic                is_end;
		logic                in_range;
		logic                k_pos;
		logic [IDX_W-1:0]    idx;    // sample index, or last index on start
		logic [POS_W-1:0]    step;
		logic [TOTAL_W-1:0]  total;
	} cmd_t;

endpackage

`default_nettype wire

### rtl/sfxlr_div.sv
// sfxlr_div: restoring divider, one quotient bit per cycle
// no package dependencies
`default_nettype none

module sfxlr_div #(
	parameter int NW = 49,
	parameter int DW = 21
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient
);
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] div_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic          fits;

	// trial subtract of the next dividend bit
	assign trial = {rem_q, quo_q[NW-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], fits};
			rem_q <= fits ? DW'(trial - {1'b0, div_q}) : trial[DW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

### rtl/sfxlr_front.sv
// sfxlr_front: byte intake, header checks, rate division and command issue
// depends on sfxlr_pkg and sfxlr_div
`default_nettype none

module sfxlr_front #(
	parameter int MAX_OUT_FRAMES = 1048576,
	parameter int FW = 21,
	parameter int DW = 21
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [sfxlr_pkg::BYTE_W-1:0]     in_byte,
	input  logic [sfxlr_pkg::LEN_W-1:0]      in_len,
	input  logic                             in_end,
	input  logic [sfxlr_pkg::RATE_W-1:0]     out_rate,
	input  logic                             q_full,
	output logic                             push,
	output sfxlr_pkg::cmd_t                  push_cmd
);
	import sfxlr_pkg::*;

	localparam int QW = 49;
	localparam logic [1:0] F_RUN  = 2'd0;
	localparam logic [1:0] F_DIV1 = 2'd1;
	localparam logic [1:0] F_DIV2 = 2'd2;
	localparam logic [1:0] F_PUSH = 2'd3;
	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_SAMPLES = 2'd1;
	localparam logic [1:0] PH_SKIP    = 2'd2;

	logic [1:0]        fstate_q;
	logic [1:0]        phase_q;
	logic [IDX_W-1:0]  byte_idx_q;
	logic [LEN_W-1:0]  held_len_q;
	logic [15:0]       hdr_rate_q;
	logic [IDX_W-1:0]  count_q;
	logic [QW-1:0]     prod_q;
	logic [FW-1:0]     frames_q;
	logic              end_hold_q;
	logic              start_q;
	cmd_t              cmd_q;

	logic              accept;
	logic [IDX_W-1:0]  idx;
	logic [LEN_W-1:0]  len_eff;
	logic [IDX_W-1:0]  cnt_full;
	logic [IDX_W-1:0]  real_now;
	logic [IDX_W-1:0]  real_cur;
	logic [IDX_W-1:0]  len_lim;
	logic [IDX_W-1:0]  k_now;
	logic              in_rng;
	logic              hdr_bad;
	logic              hdr_go;
	logic              push_now;
	cmd_t              cmd_now;
	cmd_t              div_cmd;
	logic              div_done;
	logic [QW-1:0]     div_quot;
	logic [QW-1:0]     div_num;
	logic [DW-1:0]     div_den;
	logic              quot_bad;
	logic              step_bad;

	assign accept   = in_valid && in_ready;
	assign in_ready = (fstate_q == F_RUN) && !q_full;
	assign idx      = byte_idx_q;
	assign len_eff  = (idx == '0) ? in_len : held_len_q;
	assign cnt_full = {in_byte, count_q[23:0]};
	assign real_now = cnt_full - PAD_BYTES;
	assign real_cur = count_q - PAD_BYTES;
	assign len_lim  = {1'b0, len_eff} - HEADER_LEN;
	assign k_now    = idx - LEAD_BYTES;
	assign in_rng   = (idx >= LEAD_BYTES) && (k_now < real_cur);

	// classify the byte and build its command
	always_comb begin
		hdr_bad  = 1'b0;
		hdr_go   = 1'b0;
		push_now = 1'b0;
		cmd_now          = '0;
		cmd_now.data     = in_byte;
		cmd_now.is_end   = in_end;
		cmd_now.in_range = in_rng;
		cmd_now.k_pos    = k_now != '0;
		cmd_now.idx      = k_now;
		case (phase_q)
			PH_HEADER: begin
				if (idx == 32'd0) begin
					hdr_bad = (len_eff < LEN_W'(8)) || (in_byte != MAGIC0);
				end else if (idx == 32'd1) begin
					hdr_bad = in_byte != MAGIC1;
				end else if (idx == 32'd7) begin
					hdr_bad = (cnt_full <= MIN_COUNT) || (cnt_full > len_lim)
						|| (hdr_rate_q < SRC_RATE_MIN) || ({1'b0, hdr_rate_q} > SRC_RATE_MAX);
					hdr_go = !hdr_bad;
				end
				cmd_now.kind = CMD_ERR;
				if (hdr_bad) begin
					push_now       = 1'b1;
					cmd_now.status = ST_BAD_HEADER;
				end else if (!hdr_go && in_end) begin
					push_now       = 1'b1;
					cmd_now.status = ST_EARLY_END;
				end
			end
			PH_SAMPLES: begin
				cmd_now.kind = CMD_SAMPLE;
				push_now     = in_rng || in_end;
			end
			default: ;
		endcase
	end

	// shared divider: output frame count, then the fixed point step
	assign div_num = (fstate_q == F_DIV2) ? {1'b0, real_cur, 16'h0000} : prod_q;
	assign div_den = (fstate_q == F_DIV2) ? DW'(frames_q) : DW'(hdr_rate_q);
	assign quot_bad = (div_quot == '0) || (div_quot > QW'(MAX_OUT_FRAMES));
	assign step_bad = div_quot[POS_W-1:0] <= STEP_LIMIT;

	sfxlr_div #(.NW(QW), .DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign push     = (accept && push_now) || ((fstate_q == F_PUSH) && !q_full);
	assign push_cmd = (fstate_q == F_PUSH) ? cmd_q : cmd_now;

	// command that closes the header once a division is done
	always_comb begin
		div_cmd = '0;
		if (fstate_q == F_DIV1) begin
			div_cmd.kind   = CMD_ERR;
			div_cmd.status = ST_BAD_HEADER;
		end else begin
			div_cmd.step  = div_quot[POS_W-1:0];
			div_cmd.total = TOTAL_W'(frames_q);
			div_cmd.idx   = real_cur - 1'b1;
			if (step_bad) begin
				div_cmd.kind   = CMD_ERR;
				div_cmd.status = ST_BAD_HEADER;
			end else if (end_hold_q) begin
				div_cmd.kind   = CMD_ERR;
				div_cmd.status = ST_EARLY_END;
			end else begin
				div_cmd.kind = CMD_START;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fstate_q   <= F_RUN;
			phase_q    <= PH_HEADER;
			byte_idx_q <= '0;
			start_q    <= 1'b0;
		end else begin
			start_q <= 1'b0;
			case (fstate_q)
				F_RUN: begin
					if (accept) begin
						if (in_end) begin
							byte_idx_q <= '0;
						end else if (byte_idx_q != '1) begin
							byte_idx_q <= byte_idx_q + 1'b1;
						end
						if (in_end) begin
							phase_q <= PH_HEADER;
						end else if (hdr_bad) begin
							phase_q <= PH_SKIP;
						end
						if (hdr_go) begin
							fstate_q <= F_DIV1;
							start_q  <= 1'b1;
						end
					end
				end
				F_DIV1: begin
					if (div_done) begin
						if (quot_bad) begin
							fstate_q <= F_PUSH;
							if (!end_hold_q) begin
								phase_q <= PH_SKIP;
							end
						end else begin
							fstate_q <= F_DIV2;
							start_q  <= 1'b1;
						end
					end
				end
				F_DIV2: begin
					if (div_done) begin
						fstate_q <= F_PUSH;
						if (!end_hold_q) begin
							phase_q <= step_bad ? PH_SKIP : PH_SAMPLES;
						end
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						fstate_q <= F_RUN;
					end
				end
				default: fstate_q <= F_RUN;
			endcase
		end
	end

	// header fields and the pending command
	always_ff @(posedge clk) begin
		if (accept) begin
			end_hold_q <= in_end;
			if (idx == '0) begin
				held_len_q <= in_len;
			end
			if (phase_q == PH_HEADER) begin
				if (idx == 32'd0) begin
					hdr_rate_q <= '0;
					count_q    <= '0;
				end else if (idx == 32'd2) begin
					hdr_rate_q[7:0] <= in_byte;
				end else if (idx == 32'd3) begin
					hdr_rate_q[15:8] <= in_byte;
				end else if (idx == 32'd4) begin
					count_q[7:0] <= in_byte;
				end else if (idx == 32'd5) begin
					count_q[15:8] <= in_byte;
				end else if (idx == 32'd6) begin
					count_q[23:16] <= in_byte;
				end else if (idx == 32'd7) begin
					count_q[31:24] <= in_byte;
					prod_q <= QW'(real_now) * QW'(out_rate);
				end
			end
		end
		if (fstate_q == F_DIV1 && div_done) begin
			frames_q <= div_quot[FW-1:0];
		end
		if ((fstate_q == F_DIV1 || fstate_q == F_DIV2) && div_done) begin
			cmd_q <= div_cmd;
		end
	end

endmodule

`default_nettype wire

### rtl/sfxlr_cmd_fifo.sv
// sfxlr_cmd_fifo: two-entry command queue between front and back
// depends on sfxlr_pkg
`default_nettype none

module sfxlr_cmd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sfxlr_pkg::cmd_t push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output sfxlr_pkg::cmd_t head
);
	import sfxlr_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full      = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign head      = slot_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

### rtl/sfxlr_back.sv
// sfxlr_back: interpolation engine and result register
// depends on sfxlr_pkg
`default_nettype none

module sfxlr_back #(
	parameter int FW = 21
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cmd_valid,
	input  sfxlr_pkg::cmd_t                  cmd,
	output logic                             pop,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [sfxlr_pkg::PCM_W-1:0]      out_pcm,
	output logic [sfxlr_pkg::STATUS_W-1:0]   out_status,
	output logic                             out_final
);
	import sfxlr_pkg::*;

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_LOOP = 2'd1;
	localparam logic [1:0] B_TAIL = 2'd2;

	logic [1:0]          bstate_q;
	logic                active_q;
	logic [POS_W-1:0]    step_q;
	logic [POS_W-1:0]    pos_q;
	logic [FW-1:0]       total_q;
	logic [FW-1:0]       emitted_q;
	logic [IDX_W-1:0]    last_q;
	logic [BYTE_W-1:0]   prev_q;
	logic [3:0]          burst_q;
	logic                ovalid_q;
	logic [PCM_W-1:0]    opcm_q;
	logic [STATUS_W-1:0] ostat_q;
	logic                ofin_q;

	logic                can_emit;
	logic [IDX_W-1:0]    i0;
	logic [FRAC_W-1:0]   frac;
	logic                at_last;
	logic                stop;
	logic [BYTE_W-1:0]   a_sel;
	logic signed [BYTE_W:0]   diff;
	logic signed [25:0]  prod;
	logic [9:0]          sum;
	logic [PCM_W-1:0]    blend_pcm;
	logic                emit_smp;
	logic                emit_err;
	logic [STATUS_W-1:0] err_status;
	logic                fin_now;

	assign can_emit = !ovalid_q || out_ready;
	assign i0       = pos_q[POS_W-1:FRAC_W];
	assign frac     = pos_q[FRAC_W-1:0];
	assign at_last  = i0 >= last_q;
	assign stop     = (emitted_q == total_q) || (burst_q == BURST_MAX)
		|| (at_last && cmd.idx != last_q) || (!at_last && !(i0 < cmd.idx));

	// linear blend of the two centred source bytes, floor of the fraction
	assign a_sel     = at_last ? cmd.data : prev_q;
	assign diff      = $signed({1'b0, cmd.data}) - $signed({1'b0, a_sel});
	assign prod      = 26'(diff) * 26'($signed({1'b0, frac}));
	assign sum       = 10'({1'b0, a_sel}) - 10'(CENTER) + prod[25:16];
	assign blend_pcm = {sum[7:0], 8'h00};

	assign emit_smp = (bstate_q == B_LOOP) && can_emit && !stop;
	assign fin_now  = (emitted_q + 1'b1) == total_q;

	// error results and queue pops
	always_comb begin
		emit_err   = 1'b0;
		err_status = ST_EARLY_END;
		pop        = 1'b0;
		case (bstate_q)
			B_IDLE: begin
				if (cmd_valid) begin
					if (cmd.kind == CMD_ERR) begin
						emit_err   = can_emit;
						err_status = cmd.status;
						pop        = can_emit;
					end else if (cmd.kind == CMD_START) begin
						pop = 1'b1;
					end
				end
			end
			B_TAIL: begin
				if (cmd.is_end && active_q) begin
					emit_err = can_emit;
					pop      = can_emit;
				end else begin
					pop = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// sequencer and run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bstate_q <= B_IDLE;
			active_q <= 1'b0;
		end else begin
			case (bstate_q)
				B_IDLE: begin
					if (cmd_valid) begin
						if (cmd.kind == CMD_ERR) begin
							if (can_emit) begin
								active_q <= 1'b0;
							end
						end else if (cmd.kind == CMD_START) begin
							active_q <= 1'b1;
						end else if (cmd.kind == CMD_SAMPLE) begin
							bstate_q <= (active_q && cmd.in_range && cmd.k_pos) ? B_LOOP : B_TAIL;
						end
					end
				end
				B_LOOP: begin
					if (can_emit) begin
						if (stop) begin
							bstate_q <= B_TAIL;
						end else if (fin_now) begin
							active_q <= 1'b0;
						end
					end
				end
				B_TAIL: begin
					if (pop) begin
						bstate_q <= B_IDLE;
						if (cmd.is_end) begin
							active_q <= 1'b0;
						end
					end
				end
				default: bstate_q <= B_IDLE;
			endcase
		end
	end

	// position, counters and the previous byte
	always_ff @(posedge clk) begin
		if (bstate_q == B_IDLE && cmd_valid && cmd.kind == CMD_START) begin
			step_q    <= cmd.step;
			total_q   <= cmd.total[FW-1:0];
			last_q    <= cmd.idx;
			pos_q     <= '0;
			emitted_q <= '0;
			prev_q    <= '0;
		end
		if (bstate_q == B_IDLE) begin
			burst_q <= '0;
		end
		if (emit_smp) begin
			pos_q     <= pos_q + step_q;
			emitted_q <= emitted_q + 1'b1;
			burst_q   <= burst_q + 1'b1;
		end
		if (bstate_q == B_TAIL && cmd.in_range) begin
			prev_q <= cmd.data;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (emit_smp || emit_err) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_smp) begin
			opcm_q  <= blend_pcm;
			ostat_q <= ST_SAMPLE;
			ofin_q  <= fin_now;
		end else if (emit_err) begin
			opcm_q  <= '0;
			ostat_q <= err_status;
			ofin_q  <= 1'b1;
		end
	end

	assign out_valid  = ovalid_q;
	assign out_pcm    = opcm_q;
	assign out_status = ostat_q;
	assign out_final  = ofin_q;

`ifndef NO_ASSERTIONS
	a_err_final: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && ostat_q != ST_SAMPLE |-> ofin_q && opcm_q == '0)
		else $error("error result not final or not zero");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> emitted_q <= total_q)
		else $error("emitted frames exceed total");
	a_loop_final: assert property (@(posedge clk) disable iff (!arst_n)
		bstate_q == B_LOOP && !active_q |-> emitted_q == total_q)
		else $error("run ended in loop without final frame");
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		emit_smp |-> burst_q < BURST_MAX)
		else $error("too many outputs for one byte");
`endif

endmodule

`default_nettype wire

### rtl/sfx_lump_linear_resampler_core.sv
// Channels: s_* takes one lump byte per transfer; s_tlast marks the final byte
// of the lump and s_tdata carries the byte and the lump length (length is taken
// on the first byte). m_* gives results: m_tdata the signed pcm sample, m_tuser
// the status (0 sample, 1 header rejected, 2 stream ended early), m_tlast the
// final result of the lump. cfg_wen/cfg_wdata write the output rate in hertz.
// Throughput: the intake takes one byte per cycle while the command queue has
// room; the engine gives up to eleven results for a sample byte, one per cycle
// while the receiver takes them. The eighth header byte runs the output count
// and step divisions on one shared bit-serial divider, and the next byte is
// taken only after both are done. A result reaches m_tvalid through the command
// queue and the result register; a sample result also passes the engine's loop
// state.
// A two-entry queue parts intake from the engine; the result register holds a
// result until it is taken and the engine makes the next one in that cycle; a
// stalled receiver holds m_tdata stable and back-pressures the queue and s_tready.
// Reset clears all control state, the output rate returns to 22050 and the
// next byte is taken as the start of a lump.
// depends on sfxlr_pkg, sfxlr_front, sfxlr_cmd_fifo, sfxlr_back
`default_nettype none

module sfx_lump_linear_resampler_core #(
	parameter int MAX_OUT_FRAMES = 1048576
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [39:0]                       s_tdata,   // lump_byte[7:0], lump_length[38:8], 0
	input  logic                              s_tlast,   // lump_end
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [sfxlr_pkg::PCM_W-1:0]       m_tdata,   // pcm_sample[15:0]
	output logic [sfxlr_pkg::STATUS_W-1:0]    m_tuser,   // status[1:0]
	output logic                              m_tlast,   // final_res
	input  logic                              cfg_wen,
	input  logic [sfxlr_pkg::RATE_W-1:0]      cfg_wdata
);
	import sfxlr_pkg::*;

	localparam int FW = $clog2(MAX_OUT_FRAMES + 1);
	localparam int DW = (FW > 16) ? FW : 16;

	logic [RATE_W-1:0] out_rate_q;
	logic              q_full;
	logic              push;
	cmd_t              push_cmd;
	logic              pop;
	logic              q_not_empty;
	cmd_t              head;

	// output rate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_rate_q <= 17'd22050;
		end else if (cfg_wen) begin
			out_rate_q <= cfg_wdata;
		end
	end

	sfxlr_front #(.MAX_OUT_FRAMES(MAX_OUT_FRAMES), .FW(FW), .DW(DW)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata[7:0]),
		.in_len   (s_tdata[38:8]),
		.in_end   (s_tlast),
		.out_rate (out_rate_q),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	sfxlr_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (head)
	);

	sfxlr_back #(.FW(FW)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (q_not_empty),
		.cmd        (head),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_pcm    (m_tdata),
		.out_status (m_tuser),
		.out_final  (m_tlast)
	);

endmodule

`default_nettype wire

### tb/sv/sfxlr_checker.sv
// sfxlr_checker: watches the byte and result channels of the lump resampler,
// predicts every result from the accepted bytes and compares them in order
// depends on sfxlr_pkg
`default_nettype none

module sfxlr_checker #(
	parameter int MAX_OUT_FRAMES = 1048576
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	input  wire logic                           s_tready,
	input  wire logic [39:0]                    s_tdata,   // lump_byte[7:0], lump_length[38:8], 0
	input  wire logic                           s_tlast,   // lump_end
	input  wire logic                           m_tvalid,
	input  wire logic                           m_tready,
	input  wire logic [sfxlr_pkg::PCM_W-1:0]    m_tdata,   // pcm_sample[15:0]
	input  wire logic [sfxlr_pkg::STATUS_W-1:0] m_tuser,   // status[1:0]
	input  wire logic                           m_tlast,   // final_res
	input  wire logic                           cfg_wen,
	input  wire logic [sfxlr_pkg::RATE_W-1:0]   cfg_wdata,
	output int                                  fail_count,
	output int                                  pending
);
	import sfxlr_pkg::*;

	typedef enum logic [1:0] {PH_HDR, PH_SMP, PH_SKIP} lump_phase_e;

	typedef struct {
		logic [PCM_W-1:0]    pcm;
		logic [STATUS_W-1:0] status;
		logic                fin;
	} pcm_result_t;

	pcm_result_t pcm_expected[$];

	// predicted block state
	logic [RATE_W-1:0] out_rate;
	logic [31:0]       byte_idx;
	lump_phase_e       lphase;
	logic [LEN_W-1:0]  held_len;
	logic [15:0]       hdr_rate;
	logic [31:0]       src_count;
	logic [20:0]       frames_total;
	logic [20:0]       frames_done;
	logic [47:0]       step_q;
	logic [47:0]       pos_q;
	logic [7:0]        prev_smp;

	// linear blend of two centered samples, floor of the fraction product
	function automatic logic [15:0] blend(input logic [7:0] a, input logic [7:0] b,
			input logic [15:0] frac);
		int s0, s1, prod, fl;
		s0 = int'(a) - 128;
		s1 = int'(b) - 128;
		prod = (s1 - s0) * int'(frac);
		fl = ((prod + 255 * 65536) >>> 16) - 255;
		return 16'((s0 + fl) * 256);
	endfunction

	function automatic void push_result(input logic [15:0] v, input logic [1:0] st,
			input logic fin);
		pcm_result_t r;
		r.pcm = v;
		r.status = st;
		r.fin = fin;
		pcm_expected.push_back(r);
	endfunction

	// one accepted lump byte: update state and queue its results
	task automatic resample_byte(input logic [7:0] b, input logic [LEN_W-1:0] len,
			input logic last);
		logic [31:0] idx, rl, k, lastk;
		logic [63:0] out_n, stp64;
		logic [47:0] i0;
		logic [15:0] v;
		logic        bad, fin;
		int          n;
		idx = byte_idx;
		n = 0;
		if (idx == 0) held_len = len;
		if (byte_idx != 32'hFFFF_FFFF) byte_idx++;
		case (lphase)
			PH_HDR: begin
				bad = 1'b0;
				if (idx == 0) begin
					hdr_rate = '0;
					src_count = '0;
					bad = (held_len < 8) || (b != MAGIC0);
				end else if (idx == 1) begin
					bad = (b != MAGIC1);
				end else if (idx == 2) begin
					hdr_rate = {8'h00, b};
				end else if (idx == 3) begin
					hdr_rate[15:8] = b;
				end else if (idx <= 7) begin
					src_count = src_count | (32'(b) << (8 * (idx - 4)));
					if (idx == 7) begin
						bad = 1'b1;
						if (src_count > MIN_COUNT && src_count <= 32'(held_len) - HEADER_LEN &&
								hdr_rate >= SRC_RATE_MIN && 17'(hdr_rate) <= SRC_RATE_MAX) begin
							rl = src_count - PAD_BYTES;
							out_n = 64'(rl) * 64'(out_rate) / 64'(hdr_rate);
							if (out_n >= 1 && out_n <= 64'(MAX_OUT_FRAMES)) begin
								stp64 = (64'(rl) << 16) / out_n;
								if (stp64 * 6 > 64'hFFFF) begin
									step_q = stp64[47:0];
									frames_total = out_n[20:0];
									frames_done = '0;
									pos_q = '0;
									prev_smp = '0;
									lphase = PH_SMP;
									bad = 1'b0;
								end
							end
						end
					end
				end
				if (bad) begin
					push_result('0, ST_BAD_HEADER, 1'b1);
					lphase = PH_SKIP;
				end else if (last) begin
					push_result('0, ST_EARLY_END, 1'b1);
					lphase = PH_SKIP;
				end
			end
			PH_SMP: begin
				rl = src_count - PAD_BYTES;
				if (idx >= LEAD_BYTES && idx - LEAD_BYTES < rl) begin
					k = idx - LEAD_BYTES;
					lastk = rl - 1;
					if (k >= 1) begin
						while (frames_done < frames_total && n < 11) begin
							i0 = pos_q >> 16;
							if (i0 >= 48'(lastk)) begin
								if (k != lastk) break;
								v = blend(b, b, pos_q[15:0]);
							end else if (i0 <= 48'(k - 1)) begin
								v = blend(prev_smp, b, pos_q[15:0]);
							end else begin
								break;
							end
							pos_q = pos_q + step_q;
							frames_done++;
							fin = (frames_done == frames_total);
							push_result(v, ST_SAMPLE, fin);
							n++;
							if (fin) lphase = PH_SKIP;
						end
					end
					prev_smp = b;
				end
				if (last && lphase == PH_SMP) begin
					push_result('0, ST_EARLY_END, 1'b1);
					lphase = PH_SKIP;
				end
			end
			default: ;
		endcase
		if (last) begin
			byte_idx = '0;
			lphase = PH_HDR;
		end
	endtask

	// compare each result transfer, then predict from each byte transfer
	always @(posedge clk or negedge arst_n) begin
		pcm_result_t e;
		if (!arst_n) begin
			out_rate = 17'd22050;
			byte_idx = '0;
			lphase = PH_HDR;
			held_len = '0;
			hdr_rate = '0;
			src_count = '0;
			frames_total = '0;
			frames_done = '0;
			step_q = '0;
			pos_q = '0;
			prev_smp = '0;
			pcm_expected.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_wen) out_rate = cfg_wdata;
			if (m_tvalid && m_tready) begin
				if (pcm_expected.size() == 0) begin
					$display("%0t: result with nothing expected: pcm %h status %0d last %b",
						$time, m_tdata, m_tuser, m_tlast);
					fail_count++;
				end else begin
					e = pcm_expected.pop_front();
					if (m_tdata !== e.pcm || m_tuser !== e.status || m_tlast !== e.fin) begin
						$display("%0t: mismatch: expected pcm %h status %0d last %b, got pcm %h status %0d last %b",
							$time, e.pcm, e.status, e.fin, m_tdata, m_tuser, m_tlast);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) resample_byte(s_tdata[7:0], s_tdata[38:8], s_tlast);
			pending = pcm_expected.size();
		end
	end

endmodule

`default_nettype wire

### tb/sv/tb_sfx_lump_linear_resampler_core.sv
// tb_sfx_lump_linear_resampler_core: drives sound lumps, good and broken, at
// several output rates with random idling; the verdict comes from sfxlr_checker
// depends on sfxlr_pkg, sfxlr_checker, sfx_lump_linear_resampler_core
`default_nettype none

module tb_sfx_lump_linear_resampler_core;
	import sfxlr_pkg::*;

	localparam int QUIET_LIMIT = 3000;

	typedef enum int {
		LK_GOOD, LK_EARLY, LK_BAD_M0, LK_BAD_M1, LK_SHORT, LK_BAD_CNT, LK_BAD_RATE,
		LK_HDR_END, LK_HUGE
	} lump_kind_e;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [39:0]         s_tdata;   // lump_byte[7:0], lump_length[38:8], 0
	logic                s_tlast;   // lump_end
	logic                m_tvalid;
	logic                m_tready;
	logic [PCM_W-1:0]    m_tdata;   // pcm_sample[15:0]
	logic [STATUS_W-1:0] m_tuser;   // status[1:0]
	logic                m_tlast;   // final_res
	logic                cfg_wen;
	logic [RATE_W-1:0]   cfg_wdata;
	int                  fail_count;
	int                  pending;
	int                  bytes_sent;
	int                  quiet_cycles;
	bit                  idle_on;
	bit                  long_hold;

	sfx_lump_linear_resampler_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
	);

	sfxlr_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .pending(pending)
	);

	always #5 clk = ~clk;

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// receiver: random stall bursts, one long hold on request
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
				long_hold = 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic [LEN_W-1:0] len,
			input logic last);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, len, b};
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		bytes_sent++;
	endtask

	// sender pause until all results are in and the divider has settled
	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (200) @(posedge clk);
	endtask

	task automatic set_rate(input logic [RATE_W-1:0] v);
		wait_quiet();
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic send_lump(input lump_kind_e kind, input int src, input int nreal);
		logic [7:0]       hb[8];
		logic [31:0]      cnt;
		logic [LEN_W-1:0] len;
		logic [7:0]       b;
		int               total;
		cnt = 32'(nreal) + PAD_BYTES;
		len = 31'(cnt + 8) | (($urandom_range(0, 5) == 0) ? 31'($urandom) : 31'd0);
		case (kind)
			LK_SHORT:    len = 31'($urandom_range(0, 7));
			LK_BAD_RATE: src = $urandom_range(0, 3999);
			LK_BAD_CNT:  cnt = $urandom_range(0, 1) ? $urandom_range(0, 48)
			                                        : 32'(len) - 7 + $urandom_range(0, 100);
			LK_HUGE: begin
				len = 31'h7FFF_FFFF;
				cnt = $urandom_range(32'h1000_0000, 32'h7FFF_FFF0);
			end
			default: ;
		endcase
		hb[0] = MAGIC0;
		hb[1] = MAGIC1;
		hb[2] = src[7:0];
		hb[3] = src[15:8];
		{hb[7], hb[6], hb[5], hb[4]} = cnt;
		if (kind == LK_BAD_M0) begin
			hb[0] = 8'($urandom);
			if (hb[0] == MAGIC0) hb[0] = hb[0] ^ 8'h80;
		end
		if (kind == LK_BAD_M1) hb[1] = 8'($urandom_range(1, 255));
		case (kind)
			LK_GOOD:    total = 24 + nreal + $urandom_range(0, 6);
			LK_EARLY:   total = $urandom_range(9, 24 + nreal - 1);
			LK_HDR_END: total = $urandom_range(1, 7);
			default:    total = 8 + $urandom_range(0, 6);
		endcase
		for (int i = 0; i < total; i++) begin
			if (i < 8) b = hb[i];
			else case ($urandom_range(0, 7))
				0: b = 8'h00;
				1: b = 8'hFF;
				default: b = 8'($urandom);
			endcase
			send_byte(b, len, i == total - 1);
		end
	endtask

	// random lump, mostly well-formed
	task automatic random_lump(input logic [RATE_W-1:0] rate);
		int src, pick, lo;
		lo = (rate / 5 > 4000) ? rate / 5 : 4000;
		src = ($urandom_range(0, 7) == 0) ? 4000 : $urandom_range(lo, 65535);
		pick = $urandom_range(0, 19);
		if (pick < 11) send_lump(LK_GOOD, src, $urandom_range(17, 36));
		else if (pick < 14) send_lump(LK_EARLY, src, $urandom_range(17, 36));
		else send_lump(lump_kind_e'($urandom_range(int'(LK_BAD_M0), int'(LK_HUGE))), src,
			$urandom_range(17, 36));
	endtask

	initial begin
		logic [RATE_W-1:0] rates[4];
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		bytes_sent = 0;
		quiet_cycles = 0;
		idle_on = 1'b1;
		long_hold = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: header rejections on length, magic, rate, count and frame limit, header cut short, good and early lumps
		send_lump(LK_SHORT, 11025, 17);
		send_lump(LK_BAD_M0, 11025, 17);
		send_lump(LK_BAD_M1, 11025, 17);
		send_lump(LK_BAD_RATE, 11025, 17);
		send_lump(LK_BAD_CNT, 11025, 17);
		send_lump(LK_HUGE, 4000, 17);
		send_lump(LK_HDR_END, 11025, 17);
		send_lump(LK_GOOD, 4000, 17);
		send_lump(LK_EARLY, 65535, 20);

		// random phases at several output rates, extremes included
		rates[0] = 17'd4000;
		rates[1] = 17'd96000;
		rates[2] = 17'($urandom_range(4000, 96000));
		rates[3] = 17'd22050;
		for (int p = 0; p < 4; p++) begin
			set_rate(rates[p]);
			if (p == 3) idle_on = 1'b0;
			if (p == 1) long_hold = 1'b1;
			while (bytes_sent < 150 + 52 * (p + 1)) random_lump(rates[p]);
		end

		wait_quiet();
		if (fail_count == 0 && pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
rtl/sfxlr_pkg.sv
rtl/sfxlr_div.sv
rtl/sfxlr_front.sv
rtl/sfxlr_cmd_fifo.sv
rtl/sfxlr_back.sv
rtl/sfx_lump_linear_resampler_core.sv
tb/sv/sfxlr_checker.sv
tb/sv/tb_sfx_lump_linear_resampler_core.sv
